// ===== design/pof_pkg.sv =====
// Shared types and constants of the percentile outlier flagger.
`default_nettype none
package pof_pkg;

   localparam int RES_W      = 16;   // residual field width, Q11.4
   localparam int MAG_W      = 17;   // magnitude of a residual, holds 32768
   localparam int PROD_W     = 2 * MAG_W;
   localparam int ERR_W      = 32;   // squared error, Q.8 px^2
   localparam int SCALE_W    = 36;   // 12*p and 5*err fit here
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam int INDEX_W    = 6;    // item_index field
   localparam int REMOVED_W  = 7;    // removed_count field

   // 4 px^2 in 1/256 units
   localparam logic [ERR_W-1:0] ERR_FLOOR = 32'd1024;

   // floor(8n/10) = (1640*n) >> 11 for every n up to 64
   localparam int K_MUL   = 1640;
   localparam int K_SHIFT = 11;

   typedef struct packed {
      logic [ERR_W-1:0]   max_error;
      logic [SCALE_W-1:0] p_times_12;
   } pof_limit_type;

endpackage : pof_pkg
`default_nettype wire

// ===== design/pof_judge.sv =====
// Outlier decision for one stored squared error against the set's limits.
`default_nettype none
module pof_judge
   import pof_pkg::*;
(
   input  wire logic [ERR_W-1:0] err,
   input  wire pof_limit_type    limit,
   output logic                  outlier
);

   logic [SCALE_W-1:0] err_times_5;

   // 5*err > 12*p is the exact form of err > 2.4*p
   assign err_times_5 = {2'b00, err, 2'b00} + {4'b0000, err};

   assign outlier = (err > limit.max_error) ||
                    ((err > ERR_FLOOR) && (err_times_5 > limit.p_times_12));

endmodule : pof_judge
`default_nettype wire

// ===== design/percentile_outlier_flagger.sv =====
// Top level: residual loader, rank selection sequencer and flag emitter.
//
// Usage: residual beats arrive on req_* (tdata = residual_x, residual_y; tlast
// marks the last residual of one camera's set). Each beat is squared with one
// shared multiplier and stored; req_tready is high only while the block is
// idle, so the next beat is taken only once the last is stored. Beats beyond
// MAX_ITEMS are dropped and the overflow flag of the set is raised.
// On the beat with tlast the sequencer finds the stored error at zero-based
// rank floor(8n/10) by rank counting: each candidate is read from the error
// store and compared with all n entries through its single read port. It
// then emits one flag beat per stored item on rsp_*, in load order, and
// prepares the next beat only once the last is taken; a stall holds the beat
// and the sequencer until it is taken.
// After the final beat (rsp_tlast) the set is cleared and req_tready returns.
// Reset (synchronous, active high) empties the set and sets max_error to all
// ones. csr_we writes max_error; write it only while the block is idle.
`default_nettype none
module percentile_outlier_flagger
   import pof_pkg::*;
#(
   parameter int MAX_ITEMS = 64
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // residual_x [15:0], residual_y [31:16]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tlast,
   output logic                       req_tready,
   // item_index [5:0], is_outlier [6], removed_count [13:7], overflow [14], zero [15]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tvalid,
   output logic                       rsp_tlast,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_we,
   input  wire logic [ERR_W-1:0]      csr_wdata
);

   localparam int IDX_W   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
   localparam int KPROD_W = CNT_W + K_SHIFT;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_SQ_X     = 4'd1;
   localparam logic [3:0] ST_SQ_Y     = 4'd2;
   localparam logic [3:0] ST_SEL_INIT = 4'd3;
   localparam logic [3:0] ST_CAND_RD  = 4'd4;
   localparam logic [3:0] ST_CAND_CAP = 4'd5;
   localparam logic [3:0] ST_SCAN     = 4'd6;
   localparam logic [3:0] ST_CHECK    = 4'd7;
   localparam logic [3:0] ST_EM_RD    = 4'd8;
   localparam logic [3:0] ST_EM_OUT   = 4'd9;
   localparam logic [3:0] ST_EM_WAIT  = 4'd10;

   logic [3:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ERR_W-1:0]      max_error_ff, max_error_in;

   logic [MAG_W-1:0]      mag_x_ff, mag_x_in;
   logic [MAG_W-1:0]      mag_y_ff, mag_y_in;
   logic                  last_ff, last_in;
   logic [ERR_W-1:0]      sq_ff, sq_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic [IDX_W-1:0]      i_ff, i_in;
   logic [CNT_W-1:0]      j_ff, j_in;
   logic [CNT_W-1:0]      less_ff, less_in;
   logic [CNT_W-1:0]      le_ff, le_in;
   logic [ERR_W-1:0]      cand_ff, cand_in;
   logic [SCALE_W-1:0]    p12_ff, p12_in;
   logic [CNT_W-1:0]      removed_ff, removed_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [ERR_W-1:0]      mem [MAX_ITEMS];
   logic [ERR_W-1:0]      rd_data_ff;
   logic [IDX_W-1:0]      rd_addr;
   logic                  wr_en;
   logic [ERR_W-1:0]      err_sum;

   logic [MAG_W-1:0]      mul_op;
   logic [PROD_W-1:0]     mul_prod;
   logic [KPROD_W-1:0]    k_prod;
   logic [CNT_W-1:0]      next_pos;
   logic                  outlier;
   pof_limit_type         limit;

   // shared squaring multiplier: x in state ST_SQ_X, y in state ST_SQ_Y
   assign mul_op   = (state_ff == ST_SQ_Y) ? mag_y_ff : mag_x_ff;
   assign mul_prod = mul_op * mul_op;
   assign err_sum  = sq_ff + mul_prod[ERR_W-1:0];

   assign k_prod   = KPROD_W'(count_ff) * KPROD_W'(K_MUL);
   assign next_pos = CNT_W'(i_ff) + CNT_W'(1);

   assign limit.max_error  = max_error_ff;
   assign limit.p_times_12 = p12_ff;

   pof_judge u_judge (
      .err     (rd_data_ff),
      .limit   (limit),
      .outlier (outlier)
   );

   always_comb begin
      if (state_ff == ST_SCAN) begin
         rd_addr = j_ff[IDX_W-1:0];
      end else if (state_ff == ST_CAND_CAP) begin
         rd_addr = '0;
      end else begin
         rd_addr = i_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      max_error_in = csr_we ? csr_wdata : max_error_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      last_in      = last_ff;
      sq_in        = sq_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      less_in      = less_ff;
      le_in        = le_ff;
      cand_in      = cand_ff;
      p12_in       = p12_ff;
      removed_in   = removed_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mag_x_in = req_tdata[RES_W-1] ?
                          (17'h10000 - {1'b0, req_tdata[RES_W-1:0]}) :
                          {1'b0, req_tdata[RES_W-1:0]};
               mag_y_in = req_tdata[2*RES_W-1] ?
                          (17'h10000 - {1'b0, req_tdata[2*RES_W-1:RES_W]}) :
                          {1'b0, req_tdata[2*RES_W-1:RES_W]};
               last_in  = req_tlast;
               state_in = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            sq_in    = mul_prod[ERR_W-1:0];
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            // store while there is room, otherwise drop and mark the set
            if (count_ff < CNT_W'(MAX_ITEMS)) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end else begin
               ovf_in = 1'b1;
            end
            state_in = last_ff ? ST_SEL_INIT : ST_IDLE;
         end
         ST_SEL_INIT: begin
            k_in     = CNT_W'(k_prod >> K_SHIFT);
            i_in     = '0;
            state_in = ST_CAND_RD;
         end
         ST_CAND_RD: begin
            state_in = ST_CAND_CAP;
         end
         ST_CAND_CAP: begin
            cand_in  = rd_data_ff;
            j_in     = CNT_W'(1);
            less_in  = '0;
            le_in    = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // rd_data_ff holds entry j-1
            less_in = less_ff + CNT_W'(rd_data_ff < cand_ff);
            le_in   = le_ff + CNT_W'(rd_data_ff <= cand_ff);
            if (j_ff == count_ff) begin
               state_in = ST_CHECK;
            end else begin
               j_in = j_ff + CNT_W'(1);
            end
         end
         ST_CHECK: begin
            if ((less_ff <= k_ff) && (k_ff < le_ff)) begin
               p12_in     = {1'b0, cand_ff, 3'b000} + {2'b00, cand_ff, 2'b00};
               i_in       = '0;
               removed_in = '0;
               state_in   = ST_EM_RD;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_CAND_RD;
            end
         end
         ST_EM_RD: begin
            state_in = ST_EM_OUT;
         end
         ST_EM_OUT: begin
            removed_in   = removed_ff + CNT_W'(outlier);
            rsp_data_in  = {1'b0, ovf_ff, REMOVED_W'(removed_in), outlier, INDEX_W'(i_ff)};
            rsp_last_in  = (next_pos == count_ff);
            rsp_valid_in = 1'b1;
            state_in     = ST_EM_WAIT;
         end
         ST_EM_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  i_in     = i_ff + IDX_W'(1);
                  state_in = ST_EM_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_error_ff <= '1;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         max_error_ff <= max_error_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_x_ff    <= mag_x_in;
      mag_y_ff    <= mag_y_in;
      last_ff     <= last_in;
      sq_ff       <= sq_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      less_ff     <= less_in;
      le_ff       <= le_in;
      cand_ff     <= cand_in;
      p12_ff      <= p12_in;
      removed_ff  <= removed_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // error store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= err_sum;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule : percentile_outlier_flagger
`default_nettype wire

// ===== design/pof_checker.sv =====
// Port-level checks of the percentile outlier flagger, bound to the top level.
`default_nettype none
module pof_props
   import pof_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tlast,
   input wire logic                  rsp_tready
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled rsp beat changed");

   // loading and emitting never overlap
   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("req_tready high while a rsp beat is pending");

   // the running outlier count cannot pass the number of items judged
   a_removed_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[13:7] <= ({1'b0, rsp_tdata[5:0]} + 7'd1))
      else $error("removed_count above item_index + 1");

   // after the final beat of a set the block is idle again
   a_set_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && !rsp_tvalid)
      else $error("block not idle after final rsp beat");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

endmodule : pof_props

bind percentile_outlier_flagger pof_props u_pof_props (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tlast  (rsp_tlast),
   .rsp_tready (rsp_tready)
);
`default_nettype wire

// ===== bench/pof_checker.sv =====
// Flag predictor and scoreboard for the percentile outlier flagger.
module pof_checker
   import pof_pkg::*;
#(
   parameter int MAX_ITEMS = 64
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tlast,
   input  wire logic                  req_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tlast,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_we,
   input  wire logic [ERR_W-1:0]      csr_wdata,
   output int                         mismatches,
   output int                         flags_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   // Same bit order as the response beat: tdata[14:0] with tlast on top.
   typedef struct packed {
      logic                 last_out;
      logic                 overflow;
      logic [REMOVED_W-1:0] removed_count;
      logic                 is_outlier;
      logic [INDEX_W-1:0]   item_index;
   } flag_beat_type;

   logic [ERR_W-1:0] max_error_q;
   logic [ERR_W-1:0] sq_err_mem [MAX_ITEMS];
   int               stored_count;
   logic             dropped_seen;
   flag_beat_type    expected_flags [$];
   flag_beat_type    want_beat;
   flag_beat_type    got_beat;
   int               fails;

   function automatic logic [ERR_W-1:0] squared_error(logic [REQ_DATA_W-1:0] beat);
      logic signed [RES_W-1:0] rx;
      logic signed [RES_W-1:0] ry;
      longint                  ax;
      longint                  ay;
      rx = beat[RES_W-1:0];
      ry = beat[2*RES_W-1:RES_W];
      ax = rx;
      ay = ry;
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      return ERR_W'(ax * ax + ay * ay);
   endfunction

   // Value at rank floor(8n/10) among the stored errors, by insertion sort.
   function automatic logic [ERR_W-1:0] percentile_error(int n);
      logic [ERR_W-1:0] sorted [MAX_ITEMS];
      logic [ERR_W-1:0] key;
      int               j;
      for (int i = 0; i < n; i++) sorted[i] = sq_err_mem[i];
      for (int i = 1; i < n; i++) begin
         key = sorted[i];
         j = i;
         while (j > 0 && sorted[j-1] > key) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = key;
      end
      return sorted[(n * 8) / 10];
   endfunction

   function automatic void predict_flags();
      logic [ERR_W-1:0]   p;
      logic [ERR_W-1:0]   e;
      logic [SCALE_W-1:0] e_times_5;
      logic [SCALE_W-1:0] p_times_12;
      logic               outl;
      int                 removed;
      flag_beat_type      fb;
      p = percentile_error(stored_count);
      p_times_12 = SCALE_W'(p) * 12;
      removed = 0;
      for (int i = 0; i < stored_count; i++) begin
         e = sq_err_mem[i];
         e_times_5 = SCALE_W'(e) * 5;
         outl = (e > max_error_q) || (e > ERR_FLOOR && e_times_5 > p_times_12);
         if (outl) removed++;
         fb.item_index    = INDEX_W'(i);
         fb.is_outlier    = outl;
         fb.removed_count = REMOVED_W'(removed);
         fb.overflow      = dropped_seen;
         fb.last_out      = (i == stored_count - 1);
         expected_flags = {expected_flags, fb};
      end
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         max_error_q = '1;
         stored_count = 0;
         dropped_seen = 1'b0;
         expected_flags.delete();
         fails = 0;
      end else begin
         if (csr_we) max_error_q = csr_wdata;
         if (req_tvalid && req_tready) begin
            // drop beats beyond capacity, remember that we did
            if (stored_count < MAX_ITEMS) begin
               sq_err_mem[stored_count] = squared_error(req_tdata);
               stored_count++;
            end else begin
               dropped_seen = 1'b1;
            end
            if (req_tlast) begin
               predict_flags();
               stored_count = 0;
               dropped_seen = 1'b0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got_beat = {rsp_tlast, rsp_tdata[$bits(flag_beat_type)-2:0]};
            if (expected_flags.size() == 0) begin
               $error("flag beat with nothing expected: tdata %h tlast %b",
                      rsp_tdata, rsp_tlast);
               fails++;
            end else begin
               want_beat = expected_flags.pop_front();
               check_field("item_index", want_beat.item_index, got_beat.item_index);
               check_field("is_outlier", want_beat.is_outlier, got_beat.is_outlier);
               check_field("removed_count", want_beat.removed_count,
                           got_beat.removed_count);
               check_field("overflow", want_beat.overflow, got_beat.overflow);
               check_field("last_out", want_beat.last_out, got_beat.last_out);
            end
         end
      end
      mismatches <= fails;
      flags_owed <= expected_flags.size();
   end

endmodule : pof_checker

// ===== bench/percentile_outlier_flagger_tb.sv =====
// Stimulus, flow control and verdict for the percentile outlier flagger.
module percentile_outlier_flagger_tb;
   import pof_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 64;
   localparam int RANDOM_ITEMS = 190;
   localparam int SETTLE       = 16;     // set clear after the final flag beat
   localparam int DRAIN_TAIL   = 40;
   localparam int LONG_HOLD    = 800;
   localparam int QUIET_LIMIT  = 20000;  // longer than the selection of a full set

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tlast  = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tlast;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [ERR_W-1:0]      csr_wdata  = '0;

   int mismatches;
   int flags_owed;
   int quiet_cycles;
   int random_sent;
   int set_no;
   int set_size;
   int hold_left;
   int run_left;
   bit no_gaps;
   int hold_reqs;
   int hold_seen;

   always #1 clock = ~clock;

   percentile_outlier_flagger #(.MAX_ITEMS(DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tlast  (rsp_tlast),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   pof_checker #(.MAX_ITEMS(DEPTH)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tlast  (rsp_tlast),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .flags_owed (flags_owed)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 16);
      return $urandom_range(30, 120);
   endfunction

   // small values land near the 4 px^2 floor, the rest cover the full field
   function automatic int pick_residual();
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r < 4) begin
         v = $urandom_range(0, 128);
         return v - 64;
      end
      if (r < 7) begin
         v = $urandom_range(0, 4096);
         return v - 2048;
      end
      if (r < 9) return $signed(16'($urandom));
      case ($urandom_range(0, 3))
         0:       return -32768;
         1:       return 32767;
         2:       return 0;
         default: return -1;
      endcase
   endfunction

   function automatic logic [ERR_W-1:0] pick_max_error();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(1024, 4096);
         3:       return $urandom_range(4096, 100000);
         4:       return $urandom;
         default: return 32'h8000_0000;
      endcase
   endfunction

   task automatic send_beat(input int dx, input int dy, input logic last);
      int gap;
      if (!no_gaps) begin
         gap = pick_gap();
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tdata  <= {RES_W'(dy), RES_W'(dx)};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold the input until every flag beat is in, then let the set clear
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (flags_owed != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_max_error(input logic [ERR_W-1:0] value);
      wait_drained();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // response side: random stalls, plus one long hold on request
   initial begin
      hold_left = 0;
      run_left  = 0;
      forever begin
         @(posedge clock);
         if (hold_reqs != hold_seen) begin
            hold_seen = hold_reqs;
            hold_left = LONG_HOLD;
         end
         if (hold_left == 0 && run_left == 0) begin
            hold_left = pick_gap();
            run_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                    : $urandom_range(1, 8);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            run_left--;
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      no_gaps       = 1'b0;
      random_sent   = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single zero residual under the reset clamp
      send_beat(0, 0, 1'b1);

      // field extremes and the 4 px^2 floor
      send_beat(-32768, -32768, 1'b0);
      send_beat(-32768, 0, 1'b0);
      send_beat(32767, -1, 1'b0);
      send_beat(32, 0, 1'b0);
      send_beat(33, 0, 1'b0);
      send_beat(0, -33, 1'b0);
      send_beat(1, 1, 1'b0);
      send_beat(-1, 0, 1'b1);

      // zero clamp: anything above zero is an outlier
      write_max_error('0);
      send_beat(0, 0, 1'b0);
      send_beat(0, 1, 1'b0);
      send_beat(16, 16, 1'b1);

      // clamp just above the floor
      write_max_error(32'd1500);
      send_beat(32, 0, 1'b0);
      send_beat(38, 0, 1'b0);
      send_beat(39, 0, 1'b0);
      send_beat(0, 40, 1'b0);
      send_beat(1, 1, 1'b1);

      // percentile rule alone: one large error among five small
      write_max_error('1);
      send_beat(10, 0, 1'b0);
      send_beat(0, -10, 1'b0);
      send_beat(-10, 0, 1'b0);
      send_beat(6, 8, 1'b0);
      send_beat(-8, 6, 1'b0);
      send_beat(64, 0, 1'b1);

      set_no = 0;
      while (random_sent < RANDOM_ITEMS) begin
         // sets 5 and 6 follow set 4 without a pause, behind the long hold
         if (set_no != 5 && set_no != 6) begin
            if ($urandom_range(0, 3) == 0) write_max_error(pick_max_error());
            else if ($urandom_range(0, 4) == 0) wait_drained();
         end
         no_gaps = ($urandom_range(0, 3) == 0);
         if (set_no == 2) set_size = DEPTH + 2;
         else if (set_no == 5) set_size = DEPTH;
         else if (set_no == 4) set_size = $urandom_range(2, 6);
         else if ($urandom_range(0, 5) == 0) set_size = $urandom_range(13, 30);
         else set_size = $urandom_range(1, 10);
         for (int i = 0; i < set_size; i++) begin
            if (set_no == 4 && i == set_size - 1) hold_reqs++;
            send_beat(pick_residual(), pick_residual(), i == set_size - 1);
         end
         random_sent += set_size;
         set_no++;
      end

      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatches == 0 && flags_owed == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule : percentile_outlier_flagger_tb
